>>> rtl/core/rss_pkg.sv
// shared types and constants for the raid0 stripe splitter
`timescale 1ns / 1ps

package rss_pkg;

    // fixed field widths
    localparam int LBA_FIELD_W   = 48;
    localparam int COUNT_W       = 11;
    localparam int DISK_OUT_W    = 4;
    localparam int DISK_CFG_W    = 5;
    localparam int UNIT_W        = 16;
    localparam int MUL_CNT_W     = 4;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    // request limits
    localparam logic [UNIT_W-1:0] MIN_UNIT  = 16'd32;
    localparam int PIECE_LIMIT = 33;
    localparam int PIECE_CNT_W = 6;

    // register reset values
    localparam logic [DISK_CFG_W-1:0] DISK_COUNT_RST  = 5'd4;
    localparam logic [UNIT_W-1:0]     STRIPE_UNIT_RST = 16'd64;

    // register indexes, taken from paddr[2]
    localparam logic REG_DISK_COUNT  = 1'b0;
    localparam logic REG_STRIPE_UNIT = 1'b1;

    typedef struct packed {
        logic [LBA_FIELD_W-1:0] host_lba;
        logic [COUNT_W-1:0]     sector_count;
    } rss_in_t;

    typedef struct packed {
        logic [DISK_OUT_W-1:0]  disk_index;
        logic [LBA_FIELD_W-1:0] disk_lba;
        logic [COUNT_W-1:0]     piece_sectors;
        logic                   last_piece;
    } rss_out_t;

    typedef struct packed {
        logic [DISK_CFG_W-1:0] disk_count;
        logic [UNIT_W-1:0]     stripe_unit_sectors;
    } rss_cfg_t;

    typedef enum logic [2:0] {
        RSS_IDLE,
        RSS_DIV_ROW,
        RSS_DIV_DISK,
        RSS_MUL,
        RSS_EMIT
    } rss_state_t;

endpackage

>>> rtl/core/rss_cfg_regs.sv
// apb configuration registers: disk count and stripe unit
`timescale 1ns / 1ps

module rss_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rss_pkg::PADDR_W-1:0]  paddr,
    input  logic [rss_pkg::PDATA_W-1:0]  pwdata,
    output logic [rss_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output rss_pkg::rss_cfg_t            cfg
);
    import rss_pkg::*;

    logic [DISK_CFG_W-1:0] disk_count_reg;
    logic [UNIT_W-1:0]     unit_reg;
    logic                  wr_en;
    logic                  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_count_reg <= DISK_COUNT_RST;
            unit_reg       <= STRIPE_UNIT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DISK_COUNT:  disk_count_reg <= pwdata[DISK_CFG_W-1:0];
                REG_STRIPE_UNIT: unit_reg       <= pwdata[UNIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_DISK_COUNT:  prdata = PDATA_W'(disk_count_reg);
            REG_STRIPE_UNIT: prdata = PDATA_W'(unit_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.disk_count          = disk_count_reg;
    assign cfg.stripe_unit_sectors = unit_reg;

endmodule

>>> rtl/core/rss_divider.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rss_divider
#(
    parameter int W  = 48,
    parameter int RW = 21,
    parameter int SW = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [W-1:0]  dividend,
    input  logic [RW-1:0] rem_init,
    input  logic [RW-1:0] divisor,
    input  logic [SW-1:0] steps,
    output logic          busy,
    output logic          done,
    output logic [W-1:0]  quotient,
    output logic [RW-1:0] remainder
);
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  q_reg, q_next;
    logic [RW-1:0] r_reg, r_next;
    logic [RW-1:0] d_reg, d_next;
    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {r_reg, q_reg[W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = trial >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            q_next    = dividend;
            r_next    = rem_init;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[W-2:0], fits};
            r_next   = fits ? diff[RW-1:0] : trial[RW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

>>> rtl/core/raid0_stripe_splitter.sv
// raid0 stripe splitter top level: sequencer, multiplier steps and output register
// Usage
//   in_valid/in_stall/in_data carry a host request (start sector, sector count).
//   out_valid/out_stall/out_data carry one piece per transaction, in address
//   order; last_piece marks the final piece of the request. A zero count gives
//   no pieces. An apb port sets disk_count (0x0) and stripe_unit_sectors (0x4);
//   write it only while the block is idle.
// Sequencing
//   in_stall is high from the accept until the last piece is loaded into the
//   output register. The decode runs on one shared divider: first the row
//   (address / (unit * disks)), then the disk and offset, then shift-add steps
//   for row * unit. Pieces then load one per cycle while the output register
//   is free (out_valid low or out_stall low), up to 33 per request. A pass
//   through the top of the address space reruns the decode once. Pass-through
//   (disk count zero) skips the decode and goes straight to loading its piece.
// Reset and stall
//   Reset empties the sequencer and the output register and loads disk_count 4
//   and stripe_unit_sectors 64. While out_stall is high the held piece stays
//   and the sequencer waits before loading another piece.
`timescale 1ns / 1ps

module raid0_stripe_splitter
#(
    parameter int MAX_DISKS           = 16,
    parameter int LBA_BITS            = 48,
    parameter int MAX_REQUEST_SECTORS = 1024
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  rss_pkg::rss_in_t             in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output rss_pkg::rss_out_t            out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rss_pkg::PADDR_W-1:0]  paddr,
    input  logic [rss_pkg::PDATA_W-1:0]  pwdata,
    output logic [rss_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import rss_pkg::*;

    localparam int DW       = $clog2(MAX_DISKS + 1);
    localparam int QB       = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
    localparam int RW       = UNIT_W + DW;
    localparam int CW       = $clog2(MAX_REQUEST_SECTORS + 1);
    localparam int SW       = $clog2(LBA_BITS + 1);
    localparam int CNT_CMPW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int DSK_CMPW = (DW > DISK_CFG_W) ? DW : DISK_CFG_W;
    localparam int ROOM_CMPW = (CW > UNIT_W) ? CW : UNIT_W;

    rss_cfg_t cfg;

    // sequencer state
    rss_state_t           state_reg, state_next;
    logic [LBA_BITS-1:0]  cur_reg, cur_next;
    logic [CW-1:0]        remaining_reg, remaining_next;
    logic [DW-1:0]        disks_reg, disks_next;
    logic [UNIT_W-1:0]    unit_reg, unit_next;
    logic [RW-1:0]        rowsize_reg, rowsize_next;
    logic [LBA_BITS-1:0]  row_reg, row_next;
    logic [QB-1:0]        disk_reg, disk_next;
    logic [UNIT_W-1:0]    offset_reg, offset_next;
    logic [LBA_BITS-1:0]  base_reg, base_next;
    logic                 pass_reg, pass_next;
    logic [PIECE_CNT_W-1:0] piece_cnt_reg, piece_cnt_next;
    logic [MUL_CNT_W-1:0] mul_cnt_reg, mul_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    rss_out_t             out_data_reg, out_data_next;

    // divider interface
    logic                 div_start;
    logic [LBA_BITS-1:0]  div_dividend;
    logic [RW-1:0]        div_rem_init;
    logic [RW-1:0]        div_divisor;
    logic [SW-1:0]        div_steps;
    logic                 div_busy;
    logic                 div_done;
    logic [LBA_BITS-1:0]  div_quo;
    logic [RW-1:0]        div_rem;

    // request intake values
    logic                 accept;
    logic [CNT_CMPW-1:0]  cnt_ext;
    logic [CW-1:0]        cnt_in;
    logic [DSK_CMPW-1:0]  dsk_ext;
    logic [DW-1:0]        disks_in;
    logic [UNIT_W-1:0]    unit_in;
    logic [RW-1:0]        rowsize_in;
    logic [LBA_BITS-1:0]  cur_in;

    // piece values
    logic                 slot_free;
    logic                 emit;
    logic [UNIT_W-1:0]    room;
    logic [CW-1:0]        chunk_room;
    logic [CW-1:0]        chunk;
    logic                 force_all;
    logic                 last;
    logic [LBA_BITS-1:0]  phys;
    logic [LBA_BITS:0]    cur_sum;
    logic [DW-1:0]        disk_inc;
    logic [LBA_BITS-1:0]  mul_add;

    rss_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rss_divider
    #(
        .W  (LBA_BITS),
        .RW (RW),
        .SW (SW)
    )
    u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .rem_init  (div_rem_init),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // handshake
    assign in_stall  = (state_reg != RSS_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign slot_free = !out_valid_reg || !out_stall;
    assign emit      = (state_reg == RSS_EMIT) && slot_free;

    // clamp the request and the configuration
    assign cnt_ext  = (CNT_CMPW'(in_data.sector_count) > CNT_CMPW'(MAX_REQUEST_SECTORS))
                    ? CNT_CMPW'(MAX_REQUEST_SECTORS) : CNT_CMPW'(in_data.sector_count);
    assign cnt_in   = CW'(cnt_ext);
    assign dsk_ext  = (DSK_CMPW'(cfg.disk_count) > DSK_CMPW'(MAX_DISKS))
                    ? DSK_CMPW'(MAX_DISKS) : DSK_CMPW'(cfg.disk_count);
    assign disks_in = DW'(dsk_ext);
    assign unit_in  = (cfg.stripe_unit_sectors < MIN_UNIT) ? MIN_UNIT
                    : cfg.stripe_unit_sectors;
    assign rowsize_in = RW'(unit_in) * RW'(disks_in);
    assign cur_in   = LBA_BITS'(in_data.host_lba);

    // piece length, stopping at the unit boundary unless pass-through or the piece limit takes the rest
    assign room       = unit_reg - offset_reg;
    assign chunk_room = (ROOM_CMPW'(remaining_reg) <= ROOM_CMPW'(room))
                      ? remaining_reg : CW'(room);
    assign force_all  = pass_reg || (piece_cnt_reg >= PIECE_CNT_W'(PIECE_LIMIT - 1));
    assign chunk      = force_all ? remaining_reg : chunk_room;
    assign last       = (chunk == remaining_reg);
    assign phys       = base_reg + LBA_BITS'(offset_reg);
    assign cur_sum    = {1'b0, cur_reg} + (LBA_BITS + 1)'(chunk);
    assign disk_inc   = DW'(disk_reg) + 1'b1;

    // one shift-add step of row * unit, msb of the unit first
    assign mul_add    = unit_reg[mul_cnt_reg] ? row_reg : '0;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        remaining_next = remaining_reg;
        disks_next     = disks_reg;
        unit_next      = unit_reg;
        rowsize_next   = rowsize_reg;
        row_next       = row_reg;
        disk_next      = disk_reg;
        offset_next    = offset_reg;
        base_next      = base_reg;
        pass_next      = pass_reg;
        piece_cnt_next = piece_cnt_reg;
        mul_cnt_next   = mul_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        div_dividend   = cur_in;
        div_rem_init   = '0;
        div_divisor    = rowsize_in;
        div_steps      = SW'(LBA_BITS);

        case (state_reg)
            RSS_IDLE:
            begin
                if (accept && (cnt_in != '0))
                begin
                    cur_next       = cur_in;
                    remaining_next = cnt_in;
                    disks_next     = disks_in;
                    unit_next      = unit_in;
                    rowsize_next   = rowsize_in;
                    piece_cnt_next = '0;
                    if (cfg.disk_count == '0)
                    begin
                        pass_next   = 1'b1;
                        base_next   = cur_in;
                        offset_next = '0;
                        disk_next   = '0;
                        state_next  = RSS_EMIT;
                    end
                    else
                    begin
                        pass_next  = 1'b0;
                        div_start  = 1'b1;
                        state_next = RSS_DIV_ROW;
                    end
                end
            end

            RSS_DIV_ROW:
            begin
                // row done, now split the remainder into disk and offset
                if (div_done)
                begin
                    row_next     = div_quo;
                    div_start    = 1'b1;
                    div_dividend = {div_rem[QB-1:0], {(LBA_BITS - QB){1'b0}}};
                    div_rem_init = div_rem >> QB;
                    div_divisor  = RW'(unit_reg);
                    div_steps    = SW'(QB);
                    state_next   = RSS_DIV_DISK;
                end
            end

            RSS_DIV_DISK:
            begin
                if (div_done)
                begin
                    disk_next    = div_quo[QB-1:0];
                    offset_next  = UNIT_W'(div_rem);
                    base_next    = '0;
                    mul_cnt_next = MUL_CNT_W'(UNIT_W - 1);
                    state_next   = RSS_MUL;
                end
            end

            RSS_MUL:
            begin
                base_next    = (base_reg << 1) + mul_add;
                mul_cnt_next = mul_cnt_reg - 1'b1;
                if (mul_cnt_reg == '0)
                begin
                    state_next = RSS_EMIT;
                end
            end

            RSS_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.disk_index    = DISK_OUT_W'(disk_reg);
                    out_data_next.disk_lba      = LBA_FIELD_W'(phys);
                    out_data_next.piece_sectors = COUNT_W'(chunk);
                    out_data_next.last_piece    = last;
                    remaining_next = remaining_reg - chunk;
                    piece_cnt_next = piece_cnt_reg + 1'b1;
                    cur_next       = cur_sum[LBA_BITS-1:0];
                    if (last)
                    begin
                        state_next = RSS_IDLE;
                    end
                    else if (cur_sum[LBA_BITS])
                    begin
                        // wrapped past the top of the address space: decode again
                        div_start    = 1'b1;
                        div_dividend = cur_sum[LBA_BITS-1:0];
                        div_divisor  = rowsize_reg;
                        state_next   = RSS_DIV_ROW;
                    end
                    else
                    begin
                        // next stripe unit: next disk, next row after the last disk
                        offset_next = '0;
                        if (disk_inc == disks_reg)
                        begin
                            disk_next = '0;
                            base_next = base_reg + LBA_BITS'(unit_reg);
                        end
                        else
                        begin
                            disk_next = QB'(disk_inc);
                        end
                    end
                end
            end

            default:
            begin
                state_next = RSS_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= RSS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        remaining_reg <= remaining_next;
        disks_reg     <= disks_next;
        unit_reg      <= unit_next;
        rowsize_reg   <= rowsize_next;
        row_reg       <= row_next;
        disk_reg      <= disk_next;
        offset_reg    <= offset_next;
        base_reg      <= base_next;
        pass_reg      <= pass_next;
        piece_cnt_reg <= piece_cnt_next;
        mul_cnt_reg   <= mul_cnt_next;
        out_data_reg  <= out_data_next;
    end

    // the divider only runs during the two decode states
    assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == RSS_DIV_ROW || state_reg == RSS_DIV_DISK))
        else $error("divider busy outside decode");

    // a striped piece starts inside its unit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RSS_EMIT && !pass_reg) |-> (offset_reg < unit_reg))
        else $error("offset outside stripe unit");

    // a striped piece targets an existing disk
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RSS_EMIT && !pass_reg) |-> (DW'(disk_reg) < disks_reg))
        else $error("disk index beyond disk count");

    // loading the last piece ends the request
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last) |=> (state_reg == RSS_IDLE && out_valid_reg && out_data_reg.last_piece))
        else $error("last piece did not end the request");

    // a loaded piece is never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (chunk != '0))
        else $error("empty piece");

endmodule

>>> bench/raid0_stripe_splitter_tb.sv
// self-checking testbench for the raid0 stripe splitter: directed table, random phases, apb setup
`timescale 1ns / 1ps

module raid0_stripe_splitter_tb;

    import rss_pkg::*;

    localparam int MAX_DISKS_EFF   = 16;
    localparam int MAX_REQ_SECTORS = 1024;
    localparam longint unsigned LBA_MASK = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [LBA_FIELD_W-1:0] LBA_TOP = 48'hFFFF_FFFF_FFFF;

    // idle settle after the last piece, drain at the end, no-progress limit
    localparam int SETTLE_CYCLES  = 300;
    localparam int DRAIN_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DIR_ROWS       = 22;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 43;
    localparam int PRINT_CAP      = 40;

    typedef enum logic [1:0] {
        EXP_PREDICT,
        EXP_NONE,
        EXP_ONE
    } exp_kind_t;

    typedef struct {
        exp_kind_t kind;
        rss_out_t  piece;
    } req_tag_t;

    typedef struct {
        logic [DISK_CFG_W-1:0]  disks;
        logic [UNIT_W-1:0]      unit;
        logic [LBA_FIELD_W-1:0] lba;
        logic [COUNT_W-1:0]     count;
        exp_kind_t              kind;
        logic [DISK_OUT_W-1:0]  want_disk;
        logic [LBA_FIELD_W-1:0] want_lba;
        logic [COUNT_W-1:0]     want_len;
    } dir_row_t;

    // directed requests; typed pieces only where the answer is obvious
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{5'd4,  16'd64,    48'd0,         11'd1,    EXP_ONE,     4'd0,  48'd0,    11'd1},
        '{5'd4,  16'd64,    48'd64,        11'd1,    EXP_ONE,     4'd1,  48'd0,    11'd1},
        '{5'd4,  16'd64,    48'd256,       11'd64,   EXP_ONE,     4'd0,  48'd64,   11'd64},
        '{5'd4,  16'd64,    48'd0,         11'd0,    EXP_NONE,    4'd0,  48'd0,    11'd0},
        '{5'd4,  16'd64,    48'd1,         11'd1024, EXP_PREDICT, 4'd0,  48'd0,    11'd0},
        '{5'd4,  16'd64,    48'd100,       11'd2047, EXP_PREDICT, 4'd0,  48'd0,    11'd0},
        '{5'd4,  16'd64,    48'd63,        11'd2,    EXP_PREDICT, 4'd0,  48'd0,    11'd0},
        '{5'd4,  16'd64,    LBA_TOP - 15,  11'd40,   EXP_PREDICT, 4'd0,  48'd0,    11'd0},
        '{5'd4,  16'd64,    LBA_TOP,       11'd1024, EXP_PREDICT, 4'd0,  48'd0,    11'd0},
        '{5'd0,  16'd64,    LBA_TOP,       11'd1024, EXP_ONE,     4'd0,  LBA_TOP,  11'd1024},
        '{5'd0,  16'd64,    48'd12345,     11'd2047, EXP_ONE,     4'd0,  48'd12345, 11'd1024},
        '{5'd0,  16'd64,    48'd0,         11'd0,    EXP_NONE,    4'd0,  48'd0,    11'd0},
        '{5'd0,  16'd64,    48'd5,         11'd1,    EXP_ONE,     4'd0,  48'd5,    11'd1},
        '{5'd31, 16'd0,     48'd0,         11'd1024, EXP_PREDICT, 4'd0,  48'd0,    11'd0},
        '{5'd31, 16'd0,     48'd31,        11'd1024, EXP_PREDICT, 4'd0,  48'd0,    11'd0},
        '{5'd31, 16'd0,     48'd512,       11'd1,    EXP_ONE,     4'd0,  48'd32,   11'd1},
        '{5'd31, 16'd0,     LBA_TOP,       11'd1024, EXP_PREDICT, 4'd0,  48'd0,    11'd0},
        '{5'd16, 16'd65535, 48'd0,         11'd1024, EXP_ONE,     4'd0,  48'd0,    11'd1024},
        '{5'd16, 16'd65535, 48'd983025,    11'd1,    EXP_ONE,     4'd15, 48'd0,    11'd1},
        '{5'd16, 16'd65535, 48'd65534,     11'd2,    EXP_PREDICT, 4'd0,  48'd0,    11'd0},
        '{5'd1,  16'd31,    48'd40,        11'd100,  EXP_PREDICT, 4'd0,  48'd0,    11'd0},
        '{5'd1,  16'd31,    LBA_TOP - 3,   11'd64,   EXP_PREDICT, 4'd0,  48'd0,    11'd0}
    };

    // register settings of the random phases; the last one is drawn at random
    int phase_disks [PHASES] = '{4, 1, 16, 0, 7, 31, 2, 17, 0};
    int phase_units [PHASES] = '{64, 32, 65535, 777, 48, 5, 0, 33, 0};

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    rss_in_t            in_data  = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    rss_out_t           out_data;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // testbench copy of the registers
    logic [DISK_CFG_W-1:0] disk_reg = DISK_COUNT_RST;
    logic [UNIT_W-1:0]     unit_reg = STRIPE_UNIT_RST;

    rss_out_t pending_pieces [$];
    req_tag_t req_tags [$];

    int mismatches     = 0;
    int reqs_accepted  = 0;
    int pieces_checked = 0;
    int settings_used  = 0;
    int quiet_cycles   = 0;
    int burst_left     = 0;

    // receiver stall pattern state
    int   stall_mode = 0;
    int   mode_left  = 0;
    int   run_left   = 0;
    logic run_high   = 1'b0;

    raid0_stripe_splitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // cut one request into stripe pieces and queue them in address order
    function automatic void split_request(input rss_in_t req);
        longint unsigned cur;
        longint unsigned left;
        longint unsigned disks;
        longint unsigned unit;
        longint unsigned stripe;
        longint unsigned offset;
        longint unsigned row;
        longint unsigned room;
        longint unsigned chunk;
        longint unsigned disk_sel;
        longint unsigned phys;
        int              n;
        rss_out_t        piece;
        cur  = 64'(req.host_lba);
        left = 64'(req.sector_count);
        n    = 0;
        if (left > 64'(MAX_REQ_SECTORS))
            left = 64'(MAX_REQ_SECTORS);
        if (left == 0)
            return;
        // pass-through on a disk count of zero
        if (disk_reg == 0)
        begin
            piece.disk_index    = '0;
            piece.disk_lba      = req.host_lba;
            piece.piece_sectors = left[COUNT_W-1:0];
            piece.last_piece    = 1'b1;
            pending_pieces.insert(pending_pieces.size(), piece);
            return;
        end
        disks = (disk_reg > MAX_DISKS_EFF) ? 64'(MAX_DISKS_EFF) : 64'(disk_reg);
        unit  = (unit_reg < MIN_UNIT) ? 64'(MIN_UNIT) : 64'(unit_reg);
        while (left != 0)
        begin
            stripe   = cur / unit;
            offset   = cur % unit;
            disk_sel = stripe % disks;
            row      = stripe / disks;
            phys     = (row * unit + offset) & LBA_MASK;
            room     = unit - offset;
            chunk    = (left < room) ? left : room;
            if (n + 1 >= PIECE_LIMIT)
                chunk = left;
            left = left - chunk;
            piece.disk_index    = disk_sel[DISK_OUT_W-1:0];
            piece.disk_lba      = phys[LBA_FIELD_W-1:0];
            piece.piece_sectors = chunk[COUNT_W-1:0];
            piece.last_piece    = (left == 0);
            pending_pieces.insert(pending_pieces.size(), piece);
            n++;
            cur = (cur + chunk) & LBA_MASK;
        end
    endfunction

    // accepted transactions on both channels
    always @(posedge clk)
    begin : monitor
        req_tag_t tag;
        rss_out_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            reqs_accepted++;
            tag.kind = EXP_PREDICT;
            if (req_tags.size() != 0)
                tag = req_tags.pop_front();
            case (tag.kind)
                EXP_ONE:     pending_pieces.insert(pending_pieces.size(), tag.piece);
                EXP_NONE:    ;
                default:     split_request(in_data);
            endcase
        end
        if (rst_n && out_valid && !out_stall)
        begin
            pieces_checked++;
            if (pending_pieces.size() == 0)
            begin
                report_mismatch($sformatf("unexpected piece disk %0d lba %0h len %0d",
                    out_data.disk_index, out_data.disk_lba, out_data.piece_sectors));
            end
            else
            begin
                want = pending_pieces.pop_front();
                if (out_data.disk_index !== want.disk_index)
                    report_mismatch($sformatf("piece %0d disk_index got %0d want %0d",
                        pieces_checked, out_data.disk_index, want.disk_index));
                if (out_data.disk_lba !== want.disk_lba)
                    report_mismatch($sformatf("piece %0d disk_lba got %0h want %0h",
                        pieces_checked, out_data.disk_lba, want.disk_lba));
                if (out_data.piece_sectors !== want.piece_sectors)
                    report_mismatch($sformatf("piece %0d piece_sectors got %0d want %0d",
                        pieces_checked, out_data.piece_sectors, want.piece_sectors));
                if (out_data.last_piece !== want.last_piece)
                    report_mismatch($sformatf("piece %0d last_piece got %0b want %0b",
                        pieces_checked, out_data.last_piece, want.last_piece));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver stall: free running, light, heavy, or long held runs
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= 1'($urandom_range(0, 1));
            default:
            begin
                if (run_left == 0)
                begin
                    run_high = !run_high;
                    run_left = run_high ? $urandom_range(1, 16) : $urandom_range(1, 6);
                end
                run_left--;
                out_stall <= run_high;
            end
        endcase
    end

    // put one request on the bus and hold it until taken
    task automatic send_request(input rss_in_t req, input exp_kind_t kind, input rss_out_t piece);
        req_tag_t tag;
        tag.kind  = kind;
        tag.piece = piece;
        req_tags.insert(req_tags.size(), tag);
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // sender bursts and gaps
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 24);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_pieces.size() != 0 || req_tags.size() != 0)
            @(posedge clk);
    endtask

    // apb write followed by a read back of the same register
    task automatic set_register(input logic idx, input logic [PDATA_W-1:0] value,
                                input logic [PDATA_W-1:0] field_mask);
        logic [PDATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (readback !== (value & field_mask))
            report_mismatch($sformatf("register %0d read %0h want %0h",
                idx, readback, value & field_mask));
    endtask

    // change registers only once the block has gone idle
    task automatic apply_settings(input logic [DISK_CFG_W-1:0] disks,
                                  input logic [UNIT_W-1:0] unit);
        logic [PDATA_W-1:0] word;
        if (settings_used == 0 || disks != disk_reg || unit != unit_reg)
        begin
            in_valid <= 1'b0;
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            // junk in the upper bits of the write data
            word = $urandom();
            word[DISK_CFG_W-1:0] = disks;
            set_register(REG_DISK_COUNT, word, 32'h0000_001F);
            word = $urandom();
            word[UNIT_W-1:0] = unit;
            set_register(REG_STRIPE_UNIT, word, 32'h0000_FFFF);
            disk_reg = disks;
            unit_reg = unit;
            settings_used++;
        end
    endtask

    // random request, weighted toward boundaries, small counts and the top of the space
    function automatic rss_in_t random_request();
        rss_in_t         r;
        int              pick;
        logic [63:0]     raw;
        longint unsigned unit;
        longint unsigned base;
        raw  = {$urandom(), $urandom()};
        unit = (unit_reg < MIN_UNIT) ? 64'(MIN_UNIT) : 64'(unit_reg);
        pick = $urandom_range(0, 99);
        if (pick < 5)
            r.sector_count = '0;
        else if (pick < 45)
            r.sector_count = COUNT_W'($urandom_range(1, 80));
        else if (pick < 85)
            r.sector_count = COUNT_W'($urandom_range(81, 1024));
        else if (pick < 93)
            r.sector_count = COUNT_W'($urandom_range(1025, 2047));
        else
            r.sector_count = COUNT_W'(MAX_REQ_SECTORS);
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            r.host_lba = raw[LBA_FIELD_W-1:0];
        end
        else if (pick < 65)
        begin
            r.host_lba = LBA_TOP - LBA_FIELD_W'($urandom_range(0, 2047));
        end
        else if (pick < 80)
        begin
            r.host_lba = LBA_FIELD_W'($urandom_range(0, 4095));
        end
        else
        begin
            // on or next to a stripe-unit boundary
            base = ((raw & LBA_MASK) / unit) * unit;
            base = (base + unit - 1 + 64'($urandom_range(0, 2))) & LBA_MASK;
            r.host_lba = base[LBA_FIELD_W-1:0];
        end
        return r;
    endfunction

    // stimulus
    initial
    begin : stimulus
        rss_in_t  req;
        rss_out_t piece;
        int       i;
        int       p;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed table
        for (i = 0; i < DIR_ROWS; i++)
        begin
            apply_settings(dir_rows[i].disks, dir_rows[i].unit);
            req.host_lba        = dir_rows[i].lba;
            req.sector_count    = dir_rows[i].count;
            piece.disk_index    = dir_rows[i].want_disk;
            piece.disk_lba      = dir_rows[i].want_lba;
            piece.piece_sectors = dir_rows[i].want_len;
            piece.last_piece    = 1'b1;
            send_request(req, dir_rows[i].kind, piece);
            pace();
        end

        // random phases, one register setting each
        piece = '0;
        for (p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                apply_settings(DISK_CFG_W'($urandom_range(0, 31)),
                               UNIT_W'($urandom_range(0, 65535)));
            else
                apply_settings(DISK_CFG_W'(phase_disks[p]), UNIT_W'(phase_units[p]));
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // hold off mid-phase until every piece is out
                if (i == PHASE_ITEMS / 2)
                begin
                    in_valid <= 1'b0;
                    wait_drained();
                end
                send_request(random_request(), EXP_PREDICT, piece);
                pace();
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_pieces.size() != 0)
            report_mismatch($sformatf("%0d pieces never arrived", pending_pieces.size()));

        $display("covered %0d requests (%0d from the directed table) over %0d register settings",
            reqs_accepted, DIR_ROWS, settings_used);
        $display("compared %0d pieces, %0d mismatches", pieces_checked, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
